[hw/rtl/med3_pkg.sv]
package med3_pkg;

  // frame geometry
  localparam int unsigned IMAGE_SIZE = 16;
  localparam int unsigned POS_W      = $clog2(IMAGE_SIZE);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(IMAGE_SIZE - 1);

  // wipe register and the compare against a column
  localparam int unsigned WIPE_W = 5;
  localparam int unsigned CMP_W  = (POS_W > WIPE_W) ? POS_W : WIPE_W;

  // job queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = QPTR_W + 1;

  typedef logic [7:0] pix_t;

  // one column of the window: rows r-2, r-1, r
  typedef struct packed {
    pix_t old;
    pix_t prv;
    pix_t cur;
  } col3_t;

  // one output request: 3x3 window in row-major order plus its tags
  typedef struct packed {
    pix_t [8:0]       win;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic             filt;
    logic             frame_end;
  } job_t;

  // low four bits of a position, zero-extended when positions are narrower
  function automatic logic [3:0] lo4(logic [POS_W-1:0] v);
    logic [POS_W+3:0] t;
    t = {4'b0000, v};
    return t[3:0];
  endfunction

endpackage

[hw/rtl/med3_front.sv]
module med3_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        pixel_valid_i,
  output logic                        pixel_ready_o,
  input  logic [7:0]                  pixel_i,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [med3_pkg::WIPE_W-1:0] wipe_column_i,
  input  logic                        queue_full_i,
  output logic                        job_valid_o,
  output med3_pkg::job_t              job_o
);

  // request slots produced by one pixel, in emission order
  localparam int unsigned JOB_INNER      = 0;
  localparam int unsigned JOB_EDGE       = 1;
  localparam int unsigned JOB_LAST_INNER = 2;
  localparam int unsigned JOB_LAST_EDGE  = 3;

  // line stores
  med3_pkg::pix_t prev_mem  [med3_pkg::IMAGE_SIZE];
  med3_pkg::pix_t older_mem [med3_pkg::IMAGE_SIZE];

  // input position and wipe register
  logic [med3_pkg::POS_W-1:0]  col_q, col_d, row_q, row_d;
  logic [med3_pkg::WIPE_W-1:0] wipe_q, wipe_d;

  // stage A: accepted pixel with its column of stored rows
  logic                       a_v_q, a_v_d, wb_q;
  med3_pkg::pix_t             a_pix_q, a_prev_q, a_old_q;
  logic [med3_pkg::POS_W-1:0] a_col_q, a_row_q;

  // stage D: window and pending requests
  logic [3:0]                 d_mask_q, d_mask_d, mask_after, mask_new, sel;
  logic [med3_pkg::POS_W-1:0] d_col_q, d_row_q;
  med3_pkg::col3_t            w0_q, w1_q, w2_q, a_colv;

  logic accept, d_push, a_move;
  logic edge_job, last_job, top_prv;
  logic [med3_pkg::POS_W-1:0] orow, ocol;
  med3_pkg::col3_t cl, cc, cr;

  assign cfg_ready_o = 1'b1;
  assign accept      = pixel_valid_i & pixel_ready_o;
  assign a_colv      = '{old: a_old_q, prv: a_prev_q, cur: a_pix_q};

  // dispatch: one request per cycle while the queue is not full, lowest slot first
  always_comb begin
    sel        = d_mask_q & (~d_mask_q + 4'd1);
    d_push     = (|d_mask_q) & ~queue_full_i;
    mask_after = d_push ? (d_mask_q & ~sel) : d_mask_q;
    a_move     = a_v_q & (mask_after == 4'd0);
    pixel_ready_o = ~a_v_q | a_move;
  end

  // request slots of the pixel in stage A
  always_comb begin
    mask_new = 4'd0;
    mask_new[JOB_INNER]      = (a_row_q != '0) && (a_col_q != '0);
    mask_new[JOB_EDGE]       = (a_row_q != '0) && (a_col_q == med3_pkg::LAST_POS);
    mask_new[JOB_LAST_INNER] = (a_row_q == med3_pkg::LAST_POS) && (a_col_q != '0);
    mask_new[JOB_LAST_EDGE]  = (a_row_q == med3_pkg::LAST_POS) &&
                               (a_col_q == med3_pkg::LAST_POS);
  end

  // window of the selected request, borders clamped
  always_comb begin
    edge_job = sel[JOB_EDGE] | sel[JOB_LAST_EDGE];
    last_job = sel[JOB_LAST_INNER] | sel[JOB_LAST_EDGE];
    orow     = last_job ? d_row_q : d_row_q - med3_pkg::POS_W'(1);
    ocol     = edge_job ? d_col_q : d_col_q - med3_pkg::POS_W'(1);
    cl       = edge_job ? w1_q : w0_q;
    cc       = edge_job ? w2_q : w1_q;
    cr       = w2_q;
    top_prv  = last_job | (orow == '0);

    job_o.win[0] = top_prv ? cl.prv : cl.old;
    job_o.win[1] = top_prv ? cc.prv : cc.old;
    job_o.win[2] = top_prv ? cr.prv : cr.old;
    job_o.win[3] = last_job ? cl.cur : cl.prv;
    job_o.win[4] = last_job ? cc.cur : cc.prv;
    job_o.win[5] = last_job ? cr.cur : cr.prv;
    job_o.win[6] = cl.cur;
    job_o.win[7] = cc.cur;
    job_o.win[8] = cr.cur;
    job_o.col    = ocol;
    job_o.row    = orow;
    job_o.filt   = med3_pkg::CMP_W'(ocol) < med3_pkg::CMP_W'(wipe_q);
    job_o.frame_end = (orow == med3_pkg::LAST_POS) && (ocol == med3_pkg::LAST_POS);
    job_valid_o  = d_push;
  end

  // control next state
  always_comb begin
    col_d    = col_q;
    row_d    = row_q;
    wipe_d   = cfg_valid_i ? wipe_column_i : wipe_q;
    a_v_d    = accept | (a_v_q & ~a_move);
    d_mask_d = a_move ? mask_new : mask_after;
    if (accept) begin
      if (col_q == med3_pkg::LAST_POS) begin
        col_d = '0;
        row_d = (row_q == med3_pkg::LAST_POS) ? '0 : row_q + med3_pkg::POS_W'(1);
      end else begin
        col_d = col_q + med3_pkg::POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      wipe_q   <= '0;
      a_v_q    <= 1'b0;
      wb_q     <= 1'b0;
      d_mask_q <= '0;
    end else begin
      col_q    <= col_d;
      row_q    <= row_d;
      wipe_q   <= wipe_d;
      a_v_q    <= a_v_d;
      wb_q     <= accept;
      d_mask_q <= d_mask_d;
    end
  end

  // line stores: read old column on accept, shift previous row down in the following cycle
  always_ff @(posedge clk_i) begin
    if (accept) begin
      prev_mem[col_q] <= pixel_i;
      a_prev_q        <= prev_mem[col_q];
      a_old_q         <= older_mem[col_q];
      a_pix_q         <= pixel_i;
      a_col_q         <= col_q;
      a_row_q         <= row_q;
    end
    if (wb_q) begin
      older_mem[a_col_q] <= a_prev_q;
    end
  end

  // window columns; column zero fills all three for the left border
  always_ff @(posedge clk_i) begin
    if (a_move) begin
      d_col_q <= a_col_q;
      d_row_q <= a_row_q;
      w2_q    <= a_colv;
      if (a_col_q == '0) begin
        w0_q <= a_colv;
        w1_q <= a_colv;
      end else begin
        w0_q <= w1_q;
        w1_q <= w2_q;
      end
    end
  end

endmodule

[hw/rtl/med3_queue.sv]
module med3_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  med3_pkg::job_t job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output med3_pkg::job_t job_o
);

  med3_pkg::job_t mem [med3_pkg::QUEUE_DEPTH];

  logic [med3_pkg::QPTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [med3_pkg::QCNT_W-1:0] cnt_q, cnt_d;

  localparam logic [med3_pkg::QPTR_W-1:0] PTR_LAST =
    med3_pkg::QPTR_W'(med3_pkg::QUEUE_DEPTH - 1);

  assign full_o  = cnt_q == med3_pkg::QCNT_W'(med3_pkg::QUEUE_DEPTH);
  assign valid_o = cnt_q != '0;
  assign job_o   = mem[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PTR_LAST) ? '0 : wr_q + med3_pkg::QPTR_W'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PTR_LAST) ? '0 : rd_q + med3_pkg::QPTR_W'(1);
    end
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + med3_pkg::QCNT_W'(1);
      2'b01:   cnt_d = cnt_q - med3_pkg::QCNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_q] <= job_i;
    end
  end

endmodule

[hw/rtl/med3_back.sv]
module med3_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_valid_i,
  input  med3_pkg::job_t job_i,
  output logic           job_pop_o,
  output logic           result_valid_o,
  input  logic           result_ready_i,
  output logic [7:0]     value_o,
  output logic [1:0]     color_index_o,
  output logic [3:0]     column_o,
  output logic [3:0]     row_o,
  output logic           filtered_o,
  output logic           frame_end_o
);

  typedef struct packed {
    med3_pkg::pix_t             centre;
    logic [med3_pkg::POS_W-1:0] col;
    logic [med3_pkg::POS_W-1:0] row;
    logic                       filt;
    logic                       frame_end;
  } meta_t;

  function automatic med3_pkg::pix_t max2(med3_pkg::pix_t a, med3_pkg::pix_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic med3_pkg::pix_t min2(med3_pkg::pix_t a, med3_pkg::pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic med3_pkg::pix_t mid3(med3_pkg::pix_t a, med3_pkg::pix_t b,
                                          med3_pkg::pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  // s1: each column sorted; s2: max of lows, median of mids, min of highs
  logic s1_v_q, s1_v_d, s2_v_q, s2_v_d, s3_v_q, s3_v_d;
  logic s1_rdy, s2_rdy, s3_rdy;

  med3_pkg::pix_t [2:0] s1_lo_q, s1_mid_q, s1_hi_q;
  meta_t                s1_meta_q, s2_meta_q, s3_meta_q, in_meta;
  med3_pkg::pix_t       s2_mx_q, s2_md_q, s2_mn_q, s3_value_q, med;

  assign in_meta = '{centre: job_i.win[4], col: job_i.col, row: job_i.row,
                     filt: job_i.filt, frame_end: job_i.frame_end};

  always_comb begin
    s3_rdy    = ~s3_v_q | result_ready_i;
    s2_rdy    = ~s2_v_q | s3_rdy;
    s1_rdy    = ~s1_v_q | s2_rdy;
    job_pop_o = job_valid_i & s1_rdy;
    s1_v_d    = s1_rdy ? job_valid_i : s1_v_q;
    s2_v_d    = s2_rdy ? s1_v_q : s2_v_q;
    s3_v_d    = s3_rdy ? s2_v_q : s3_v_q;
    med       = mid3(s2_mx_q, s2_md_q, s2_mn_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      s1_v_q <= s1_v_d;
      s2_v_q <= s2_v_d;
      s3_v_q <= s3_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      for (int k = 0; k < 3; k++) begin
        s1_lo_q[k]  <= min2(min2(job_i.win[k], job_i.win[k+3]), job_i.win[k+6]);
        s1_mid_q[k] <= mid3(job_i.win[k], job_i.win[k+3], job_i.win[k+6]);
        s1_hi_q[k]  <= max2(max2(job_i.win[k], job_i.win[k+3]), job_i.win[k+6]);
      end
      s1_meta_q <= in_meta;
    end
    if (s2_rdy && s1_v_q) begin
      s2_mx_q   <= max2(max2(s1_lo_q[0], s1_lo_q[1]), s1_lo_q[2]);
      s2_md_q   <= mid3(s1_mid_q[0], s1_mid_q[1], s1_mid_q[2]);
      s2_mn_q   <= min2(min2(s1_hi_q[0], s1_hi_q[1]), s1_hi_q[2]);
      s2_meta_q <= s1_meta_q;
    end
    if (s3_rdy && s2_v_q) begin
      s3_value_q <= s2_meta_q.filt ? med : s2_meta_q.centre;
      s3_meta_q  <= s2_meta_q;
    end
  end

  assign result_valid_o = s3_v_q;
  assign value_o        = s3_value_q;
  assign color_index_o  = s3_value_q[5:4];
  assign column_o       = med3_pkg::lo4(s3_meta_q.col);
  assign row_o          = med3_pkg::lo4(s3_meta_q.row);
  assign filtered_o     = s3_meta_q.filt;
  assign frame_end_o    = s3_meta_q.frame_end;

endmodule

[hw/rtl/median3x3_replicate_border.sv]
// Channel   Direction  Handshake                        Payload
// pixel     in         pixel_valid_i / pixel_ready_o    pixel_i
// cfg       in         cfg_valid_i / cfg_ready_o        wipe_column_i
// result    out        result_valid_o / result_ready_i  value_o, color_index_o, column_o,
//                                                       row_o, filtered_o, frame_end_o
//
// One pixel per cycle while each pixel yields at most one result and the job queue is
// not full; a pixel that yields several results holds the front's dispatch stage until
// all are pushed (two on the right edge or in the last row, four for the last pixel of
// the frame), since the dispatch pushes one request a cycle.
// Reset clears position, wipe column and all valid flags; line stores are not cleared.
// A full job queue stalls the front only; a stalled result stalls the back, and the front once the queue fills.
module median3x3_replicate_border (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // pixel stream in
  input  logic                        pixel_valid_i,
  output logic                        pixel_ready_o,
  input  logic [7:0]                  pixel_i,
  // wipe column register write
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [med3_pkg::WIPE_W-1:0] wipe_column_i,
  // filtered pixels out
  output logic                        result_valid_o,
  input  logic                        result_ready_i,
  output logic [7:0]                  value_o,
  output logic [1:0]                  color_index_o,
  output logic [3:0]                  column_o,
  output logic [3:0]                  row_o,
  output logic                        filtered_o,
  output logic                        frame_end_o
);

  // front -> queue
  logic           push, queue_full;
  med3_pkg::job_t push_job;

  // queue -> back
  logic           pop, queue_valid;
  med3_pkg::job_t head_job;

  // Front: line stores, window columns and border clamping. Each pixel is
  // classified into up to four output requests (interior, right edge, and the
  // same two again for the last row), pushed one per cycle while the queue is not full.
  med3_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pixel_valid_i (pixel_valid_i),
    .pixel_ready_o (pixel_ready_o),
    .pixel_i       (pixel_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .wipe_column_i (wipe_column_i),
    .queue_full_i  (queue_full),
    .job_valid_o   (push),
    .job_o         (push_job)
  );

  // Short request queue decoupling the two halves.
  med3_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (queue_full),
    .pop_i   (pop),
    .valid_o (queue_valid),
    .job_o   (head_job)
  );

  // Back: three-stage median of nine (column sort, cross reduce, final median3)
  // with the last stage acting as the output register.
  med3_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_valid_i    (queue_valid),
    .job_i          (head_job),
    .job_pop_o      (pop),
    .result_valid_o (result_valid_o),
    .result_ready_i (result_ready_i),
    .value_o        (value_o),
    .color_index_o  (color_index_o),
    .column_o       (column_o),
    .row_o          (row_o),
    .filtered_o     (filtered_o),
    .frame_end_o    (frame_end_o)
  );

endmodule
